[design/tfsc_pkg.sv]
`timescale 1ns / 1ps

// Shared types, codes and reset values for the tape feeder step controller.
package tfsc_pkg;

    // Field widths of the configuration registers.
    localparam int DebW     = 10;
    localparam int DivW     = 8;
    localparam int HoldW    = 12;
    localparam int EdgeW    = 8;
    localparam int PauseW   = 16;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 16;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_SENSOR_DEB  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_COMMAND_DEB = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_BUTTON_DIV  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_BUTTON_DEB  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_LONG_PRESS  = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_FEED_EDGES  = 3'd5;
    localparam logic [CfgIdxW-1:0] CFG_PAUSE       = 3'd6;

    // Configuration reset values.
    localparam logic [DebW-1:0]   RST_SENSOR_DEB  = 10'd10;
    localparam logic [DebW-1:0]   RST_COMMAND_DEB = 10'd40;
    localparam logic [DivW-1:0]   RST_BUTTON_DIV  = 8'd10;
    localparam logic [DebW-1:0]   RST_BUTTON_DEB  = 10'd50;
    localparam logic [HoldW-1:0]  RST_LONG_PRESS  = 12'd800;
    localparam logic [EdgeW-1:0]  RST_FEED_EDGES  = 8'd5;
    localparam logic [PauseW-1:0] RST_PAUSE       = 16'd1000;

    // Sequencer phase, as shown on the phase output.
    typedef enum logic [1:0] {
        PH_HOMING = 2'd0,
        PH_IDLE   = 2'd1,
        PH_FEED   = 2'd2,
        PH_BACK   = 2'd3
    } t_phase;

    // Reel motor drive codes.
    localparam logic [1:0] REEL_STOP = 2'd0;
    localparam logic [1:0] REEL_FWD  = 2'd1;
    localparam logic [1:0] REEL_BACK = 2'd2;

    // Outcome of one debounce sample.
    typedef struct packed {
        logic            level;
        logic [DebW-1:0] count;
        logic            toggle;
    } t_deb;

    // One debounce sample: a mismatch counts up; at the limit the level toggles
    // and the count holds at the limit; a match clears the count.
    function automatic t_deb debounce(
        input logic            pin,
        input logic            level,
        input logic [DebW-1:0] count,
        input logic [DebW-1:0] limit
    );
        t_deb          res;
        logic [DebW:0] sum;
        res.level  = level;
        res.count  = count;
        res.toggle = 1'b0;
        sum        = {1'b0, count} + {{DebW{1'b0}}, 1'b1};
        if (pin == level) begin
            res.count = '0;
        end else if (sum >= {1'b0, limit}) begin
            res.count  = limit;
            res.level  = ~level;
            res.toggle = 1'b1;
        end else begin
            res.count = sum[DebW-1:0];
        end
        return res;
    endfunction

endpackage

[design/tape_feeder_step_controller.sv]
`timescale 1ns / 1ps

// Channel   | Handshake                 | Payload
// ----------+---------------------------+----------------------------------------------
// tick in   | i_valid / o_stall         | i_sensor_pin, i_button_pin, i_command_pin
// result    | o_valid / i_stall         | o_reel_drive, o_tape_drive, o_led_on,
//           |                           | o_phase, o_pausing
// config    | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Each tick is processed in the cycle it is accepted: the debouncers, the button
// divider and the sequencer update together, and the result is registered.
// One tick per cycle is sustained while the skid buffer is empty; the result register plus a one-entry skid
// buffer keep the input open while one result waits on a stalled output.
// o_stall rises only when the skid buffer holds a result.
// Reset is synchronous and active low and restores all state and registers but the result and skid data.
module tape_feeder_step_controller (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Tick input channel.
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic                             i_sensor_pin,
    input  logic                             i_button_pin,
    input  logic                             i_command_pin,
    // Result channel.
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [1:0]                       o_reel_drive,
    output logic                             o_tape_drive,
    output logic                             o_led_on,
    output logic [1:0]                       o_phase,
    output logic                             o_pausing,
    // Configuration write port.
    input  logic                             i_cfg_we,
    input  logic [tfsc_pkg::CfgIdxW-1:0]     i_cfg_idx,
    input  logic [tfsc_pkg::CfgDataW-1:0]    i_cfg_data
);

    typedef struct packed {
        logic [1:0] reel;
        logic       tape;
        logic       led;
        logic [1:0] phase;
        logic       pausing;
    } t_result;

    // Configuration registers.
    logic [tfsc_pkg::DebW-1:0]   r_cfg_sensor_deb;
    logic [tfsc_pkg::DebW-1:0]   r_cfg_command_deb;
    logic [tfsc_pkg::DivW-1:0]   r_cfg_button_div;
    logic [tfsc_pkg::DebW-1:0]   r_cfg_button_deb;
    logic [tfsc_pkg::HoldW-1:0]  r_cfg_long_press;
    logic [tfsc_pkg::EdgeW-1:0]  r_cfg_feed_edges;
    logic [tfsc_pkg::PauseW-1:0] r_cfg_pause;

    // Controller state and its next values.
    tfsc_pkg::t_phase            r_phase, n_phase;
    logic [tfsc_pkg::PauseW-1:0] r_pause_left, n_pause_left;
    logic                        r_sensor_level, n_sensor_level;
    logic                        r_button_level, n_button_level;
    logic                        r_command_level, n_command_level;
    logic [tfsc_pkg::DebW-1:0]   r_sensor_count, n_sensor_count;
    logic [tfsc_pkg::DebW-1:0]   r_command_count, n_command_count;
    logic [tfsc_pkg::DebW-1:0]   r_button_count, n_button_count;
    logic [tfsc_pkg::HoldW-1:0]  r_hold_count, n_hold_count;
    logic [tfsc_pkg::DivW-1:0]   r_div_count, n_div_count;
    logic                        r_long_held, n_long_held;
    logic                        r_short_event, n_short_event;
    logic                        r_long_event, n_long_event;
    logic                        r_command_event, n_command_event;
    logic [tfsc_pkg::EdgeW-1:0]  r_edges_left, n_edges_left;
    logic [1:0]                  r_falls_left, n_falls_left;
    logic [1:0]                  r_reel, n_reel;
    logic                        r_tape, n_tape;
    logic                        r_led, n_led;

    // Output register and skid buffer.
    t_result r_out, r_skid, n_result;
    logic    r_out_valid, r_skid_valid;

    logic in_fire, out_take;

    assign o_stall  = r_skid_valid;
    assign in_fire  = i_valid && !r_skid_valid;
    assign out_take = r_out_valid && !i_stall;

    // Next state for one tick.
    always_comb begin
        logic                      idle;
        logic                      do_finish;
        logic                      do_end;
        logic [tfsc_pkg::DivW:0]   div_sum;
        logic [tfsc_pkg::HoldW:0]  hold_sum;
        tfsc_pkg::t_deb            deb_b;
        tfsc_pkg::t_deb            deb_s;
        tfsc_pkg::t_deb            deb_c;

        n_phase         = r_phase;
        n_pause_left    = r_pause_left;
        n_sensor_level  = r_sensor_level;
        n_button_level  = r_button_level;
        n_command_level = r_command_level;
        n_sensor_count  = r_sensor_count;
        n_command_count = r_command_count;
        n_button_count  = r_button_count;
        n_hold_count    = r_hold_count;
        n_div_count     = r_div_count;
        n_long_held     = r_long_held;
        n_short_event   = r_short_event;
        n_long_event    = r_long_event;
        n_command_event = r_command_event;
        n_edges_left    = r_edges_left;
        n_falls_left    = r_falls_left;
        n_reel          = r_reel;
        n_tape          = r_tape;
        n_led           = r_led;
        do_finish       = 1'b0;
        do_end          = 1'b0;
        idle            = (r_phase == tfsc_pkg::PH_IDLE);

        // Button divider, with the button sampled only while idle.
        div_sum  = {1'b0, r_div_count} + {{tfsc_pkg::DivW{1'b0}}, 1'b1};
        deb_b    = tfsc_pkg::debounce(i_button_pin, r_button_level, r_button_count,
                                      r_cfg_button_deb);
        hold_sum = {1'b0, r_hold_count} + {{tfsc_pkg::HoldW{1'b0}}, 1'b1};
        if (div_sum >= {1'b0, r_cfg_button_div}) begin
            n_div_count = '0;
            if (idle) begin
                n_button_level = deb_b.level;
                n_button_count = deb_b.count;
                // A release ends either a short or a long press.
                if (deb_b.toggle && deb_b.level) begin
                    if (r_long_held) begin
                        n_long_held  = 1'b0;
                        n_long_event = 1'b1;
                    end else begin
                        n_short_event = 1'b1;
                    end
                end
                // Hold time of the raw button, saturating at the long-press limit.
                if (!i_button_pin) begin
                    if (hold_sum >= {1'b0, r_cfg_long_press}) begin
                        n_hold_count = r_cfg_long_press;
                        n_long_held  = 1'b1;
                    end else begin
                        n_hold_count = hold_sum[tfsc_pkg::HoldW-1:0];
                    end
                end else begin
                    n_hold_count = '0;
                end
            end
        end else begin
            n_div_count = div_sum[tfsc_pkg::DivW-1:0];
        end

        // Sensor debounce; every accepted edge counts down the feed edges, every accepted fall the backward falls.
        deb_s          = tfsc_pkg::debounce(i_sensor_pin, r_sensor_level, r_sensor_count,
                                            r_cfg_sensor_deb);
        n_sensor_level = deb_s.level;
        n_sensor_count = deb_s.count;
        if (deb_s.toggle) begin
            if (r_edges_left != '0) begin
                n_edges_left = r_edges_left - {{(tfsc_pkg::EdgeW-1){1'b0}}, 1'b1};
            end
            if (!deb_s.level && r_falls_left != 2'd0) begin
                n_falls_left = r_falls_left - 2'd1;
            end
        end

        // Command debounce while idle; an asserting edge requests a feed.
        deb_c = tfsc_pkg::debounce(i_command_pin, r_command_level, r_command_count,
                                   r_cfg_command_deb);
        if (idle) begin
            n_command_level = deb_c.level;
            n_command_count = deb_c.count;
            if (deb_c.toggle && !deb_c.level) begin
                n_command_event = 1'b1;
            end
        end

        // Sequencer.
        if (r_pause_left != '0) begin
            n_pause_left = r_pause_left - {{(tfsc_pkg::PauseW-1){1'b0}}, 1'b1};
            do_end       = (n_pause_left == '0);
        end else begin
            case (r_phase)
                tfsc_pkg::PH_HOMING: begin
                    do_finish = !n_sensor_level;
                end
                tfsc_pkg::PH_IDLE: begin
                    if (n_short_event || n_long_event || n_command_event) begin
                        n_led  = 1'b0;
                        n_tape = 1'b0;
                        if (n_short_event || n_command_event) begin
                            n_edges_left = r_cfg_feed_edges;
                        end
                        if (n_long_event) begin
                            n_falls_left = 2'd1;
                        end
                        // Command wins over a long press, a long press over a short one.
                        if (n_command_event || !n_long_event) begin
                            n_reel  = tfsc_pkg::REEL_FWD;
                            n_phase = tfsc_pkg::PH_FEED;
                        end else begin
                            n_reel  = tfsc_pkg::REEL_BACK;
                            n_phase = tfsc_pkg::PH_BACK;
                        end
                        n_short_event   = 1'b0;
                        n_long_event    = 1'b0;
                        n_command_event = 1'b0;
                    end
                end
                tfsc_pkg::PH_FEED: begin
                    do_finish = (n_edges_left == '0);
                end
                tfsc_pkg::PH_BACK: begin
                    do_finish = (n_falls_left == 2'd0);
                end
                default: begin
                    do_finish = 1'b0;
                end
            endcase
        end

        // A finished move stops the reel and starts the pause.
        if (do_finish) begin
            n_reel = tfsc_pkg::REEL_STOP;
            if (r_phase == tfsc_pkg::PH_FEED) begin
                n_led = 1'b1;
            end
            if (r_cfg_pause == '0) begin
                do_end = 1'b1;
            end else begin
                n_pause_left = r_cfg_pause;
            end
        end

        // End of the pause: a feed goes back to homing, anything else to idle.
        if (do_end) begin
            if (r_phase == tfsc_pkg::PH_FEED) begin
                n_reel  = tfsc_pkg::REEL_BACK;
                n_phase = tfsc_pkg::PH_HOMING;
            end else begin
                if (r_phase == tfsc_pkg::PH_BACK) begin
                    n_led = 1'b1;
                end
                n_tape  = 1'b1;
                n_phase = tfsc_pkg::PH_IDLE;
            end
        end

        n_result.reel    = n_reel;
        n_result.tape    = n_tape;
        n_result.led     = n_led;
        n_result.phase   = n_phase;
        n_result.pausing = (n_pause_left != '0);
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sensor_deb  <= tfsc_pkg::RST_SENSOR_DEB;
            r_cfg_command_deb <= tfsc_pkg::RST_COMMAND_DEB;
            r_cfg_button_div  <= tfsc_pkg::RST_BUTTON_DIV;
            r_cfg_button_deb  <= tfsc_pkg::RST_BUTTON_DEB;
            r_cfg_long_press  <= tfsc_pkg::RST_LONG_PRESS;
            r_cfg_feed_edges  <= tfsc_pkg::RST_FEED_EDGES;
            r_cfg_pause       <= tfsc_pkg::RST_PAUSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tfsc_pkg::CFG_SENSOR_DEB:  r_cfg_sensor_deb  <= i_cfg_data[tfsc_pkg::DebW-1:0];
                tfsc_pkg::CFG_COMMAND_DEB: r_cfg_command_deb <= i_cfg_data[tfsc_pkg::DebW-1:0];
                tfsc_pkg::CFG_BUTTON_DIV:  r_cfg_button_div  <= i_cfg_data[tfsc_pkg::DivW-1:0];
                tfsc_pkg::CFG_BUTTON_DEB:  r_cfg_button_deb  <= i_cfg_data[tfsc_pkg::DebW-1:0];
                tfsc_pkg::CFG_LONG_PRESS:  r_cfg_long_press  <= i_cfg_data[tfsc_pkg::HoldW-1:0];
                tfsc_pkg::CFG_FEED_EDGES:  r_cfg_feed_edges  <= i_cfg_data[tfsc_pkg::EdgeW-1:0];
                tfsc_pkg::CFG_PAUSE:       r_cfg_pause       <= i_cfg_data[tfsc_pkg::PauseW-1:0];
                default: begin
                end
            endcase
        end
    end

    // Controller state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= tfsc_pkg::PH_HOMING;
            r_pause_left    <= '0;
            r_sensor_level  <= 1'b0;
            r_button_level  <= 1'b1;
            r_command_level <= 1'b0;
            r_sensor_count  <= '0;
            r_command_count <= '0;
            r_button_count  <= '0;
            r_hold_count    <= '0;
            r_div_count     <= '0;
            r_long_held     <= 1'b0;
            r_short_event   <= 1'b0;
            r_long_event    <= 1'b0;
            r_command_event <= 1'b0;
            r_edges_left    <= '0;
            r_falls_left    <= 2'd0;
            r_reel          <= tfsc_pkg::REEL_BACK;
            r_tape          <= 1'b0;
            r_led           <= 1'b1;
        end else if (in_fire) begin
            r_phase         <= n_phase;
            r_pause_left    <= n_pause_left;
            r_sensor_level  <= n_sensor_level;
            r_button_level  <= n_button_level;
            r_command_level <= n_command_level;
            r_sensor_count  <= n_sensor_count;
            r_command_count <= n_command_count;
            r_button_count  <= n_button_count;
            r_hold_count    <= n_hold_count;
            r_div_count     <= n_div_count;
            r_long_held     <= n_long_held;
            r_short_event   <= n_short_event;
            r_long_event    <= n_long_event;
            r_command_event <= n_command_event;
            r_edges_left    <= n_edges_left;
            r_falls_left    <= n_falls_left;
            r_reel          <= n_reel;
            r_tape          <= n_tape;
            r_led           <= n_led;
        end
    end

    // Result register with a one-entry skid buffer behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_take || !r_out_valid) begin
            r_out_valid  <= r_skid_valid || in_fire;
            r_skid_valid <= 1'b0;
        end else if (in_fire) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_take || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : n_result;
        end
        if (in_fire && r_out_valid && !out_take) begin
            r_skid <= n_result;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_reel_drive = r_out.reel;
    assign o_tape_drive = r_out.tape;
    assign o_led_on     = r_out.led;
    assign o_phase      = r_out.phase;
    assign o_pausing    = r_out.pausing;

`ifndef SYNTHESIS
    // The skid buffer only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid buffer holds a transaction while the output is empty");

    // A tick accepted behind a stalled result lands in the skid buffer.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("transaction accepted behind a stalled result was lost");

    // A pause never runs while idle.
    a_no_idle_pause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pause_left != '0) |-> (r_phase != tfsc_pkg::PH_IDLE))
        else $error("pause running in idle");

    // The reel only runs forward during a feed.
    a_reel_fwd_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_reel == tfsc_pkg::REEL_FWD) |-> (r_phase == tfsc_pkg::PH_FEED))
        else $error("reel forward outside a feed");

    // Press and command events are consumed on the tick that raises them.
    a_events_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_short_event || r_long_event || r_command_event))
        else $error("event left pending after a tick");
`endif

endmodule

[test/tape_feeder_step_controller_tb.sv]
`timescale 1ns / 1ps

module tape_feeder_step_controller_tb;
    import tfsc_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int PhaseTicks = 195;
    localparam int NumPhases  = 10;
    localparam int RunCap     = 400;

    // Motor, LED and phase levels that one tick leaves on the outputs.
    typedef struct packed {
        logic [1:0] reel;
        logic       tape;
        logic       led;
        t_phase     phase;
        logic       pausing;
    } drive_t;

    // One debounce sample: new level, new mismatch count and whether it toggled.
    typedef struct packed {
        logic            lvl;
        logic [DebW-1:0] cnt;
        logic            flip;
    } filt_t;

    // Predicts the drive outputs of every accepted tick and checks the results.
    class tick_scoreboard;
        logic [DebW-1:0]   sens_deb, cmd_deb, btn_deb;
        logic [DivW-1:0]   btn_div;
        logic [HoldW-1:0]  long_lim;
        logic [EdgeW-1:0]  feed_cfg;
        logic [PauseW-1:0] pause_cfg;

        t_phase            ph;
        logic [PauseW-1:0] pause_left;
        logic              sens_lvl, btn_lvl, cmd_lvl;
        logic [DebW-1:0]   sens_cnt, cmd_cnt, btn_cnt;
        logic [HoldW-1:0]  hold_cnt;
        logic [DivW-1:0]   div_cnt;
        logic              long_held, short_ev, long_ev, cmd_ev;
        logic [EdgeW-1:0]  edges_left;
        logic [1:0]        falls_left;
        logic [1:0]        reel;
        logic              tape, led;

        drive_t            due_drives[$];
        int                errors;
        int                results_seen;

        function new();
            sens_deb   = RST_SENSOR_DEB;
            cmd_deb    = RST_COMMAND_DEB;
            btn_div    = RST_BUTTON_DIV;
            btn_deb    = RST_BUTTON_DEB;
            long_lim   = RST_LONG_PRESS;
            feed_cfg   = RST_FEED_EDGES;
            pause_cfg  = RST_PAUSE;
            ph         = PH_HOMING;
            pause_left = '0;
            sens_lvl   = 1'b0;
            btn_lvl    = 1'b1;
            cmd_lvl    = 1'b0;
            sens_cnt   = '0;
            cmd_cnt    = '0;
            btn_cnt    = '0;
            hold_cnt   = '0;
            div_cnt    = '0;
            long_held  = 1'b0;
            short_ev   = 1'b0;
            long_ev    = 1'b0;
            cmd_ev     = 1'b0;
            edges_left = '0;
            falls_left = '0;
            reel       = REEL_BACK;
            tape       = 1'b0;
            led        = 1'b1;
            errors       = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
            case (idx)
                CFG_SENSOR_DEB:  sens_deb  = data[DebW-1:0];
                CFG_COMMAND_DEB: cmd_deb   = data[DebW-1:0];
                CFG_BUTTON_DIV:  btn_div   = data[DivW-1:0];
                CFG_BUTTON_DEB:  btn_deb   = data[DebW-1:0];
                CFG_LONG_PRESS:  long_lim  = data[HoldW-1:0];
                CFG_FEED_EDGES:  feed_cfg  = data[EdgeW-1:0];
                CFG_PAUSE:       pause_cfg = data[PauseW-1:0];
                default: ;
            endcase
        endfunction

        // A mismatch must persist for lim samples; the count then sticks at lim.
        function filt_t settle(logic pin, logic lvl, logic [DebW-1:0] cnt,
                               logic [DebW-1:0] lim);
            filt_t       r;
            int unsigned n;
            r.lvl  = lvl;
            r.cnt  = cnt;
            r.flip = 1'b0;
            if (pin == lvl) begin
                r.cnt = '0;
            end else begin
                n = cnt + 1;
                if (n >= lim) begin
                    r.cnt  = lim;
                    r.lvl  = ~lvl;
                    r.flip = 1'b1;
                end else begin
                    r.cnt = n[DebW-1:0];
                end
            end
            return r;
        endfunction

        // A debounced release is a long press if the hold counter saturated first.
        function void sample_button(logic pin);
            filt_t       f;
            int unsigned n;
            f       = settle(pin, btn_lvl, btn_cnt, btn_deb);
            btn_lvl = f.lvl;
            btn_cnt = f.cnt;
            if (f.flip && btn_lvl) begin
                if (long_held) begin
                    long_held = 1'b0;
                    long_ev   = 1'b1;
                end else begin
                    short_ev = 1'b1;
                end
            end
            if (!pin) begin
                n = hold_cnt + 1;
                if (n >= long_lim) begin
                    hold_cnt  = long_lim;
                    long_held = 1'b1;
                end else begin
                    hold_cnt = n[HoldW-1:0];
                end
            end else begin
                hold_cnt = '0;
            end
        endfunction

        function void end_pause();
            if (ph == PH_FEED) begin
                reel = REEL_BACK;
                ph   = PH_HOMING;
            end else begin
                if (ph == PH_BACK)
                    led = 1'b1;
                tape = 1'b1;
                ph   = PH_IDLE;
            end
        endfunction

        function void finish_move();
            reel = REEL_STOP;
            if (ph == PH_FEED)
                led = 1'b1;
            if (pause_cfg == 0)
                end_pause();
            else
                pause_left = pause_cfg;
        endfunction

        // Advance the predicted state by one accepted tick and queue its drive levels.
        function void note_tick(logic s, logic b, logic c);
            logic        idle;
            filt_t       f;
            int unsigned n;
            drive_t      d;
            idle = (ph == PH_IDLE);

            // Button divider; the button is only sampled while idle.
            n = div_cnt + 1;
            if (n >= btn_div) begin
                div_cnt = '0;
                if (idle)
                    sample_button(b);
            end else begin
                div_cnt = n[DivW-1:0];
            end

            // Sensor edges count down the feed and the backward move.
            f        = settle(s, sens_lvl, sens_cnt, sens_deb);
            sens_lvl = f.lvl;
            sens_cnt = f.cnt;
            if (f.flip) begin
                if (edges_left != 0)
                    edges_left = edges_left - 1'b1;
                if (!sens_lvl && falls_left != 0)
                    falls_left = falls_left - 1'b1;
            end

            // The command pin is debounced only while idle.
            if (idle) begin
                f       = settle(c, cmd_lvl, cmd_cnt, cmd_deb);
                cmd_lvl = f.lvl;
                cmd_cnt = f.cnt;
                if (f.flip && !cmd_lvl)
                    cmd_ev = 1'b1;
            end

            // Sequencer: a running pause only counts down.
            if (pause_left != 0) begin
                pause_left = pause_left - 1'b1;
                if (pause_left == 0)
                    end_pause();
            end else begin
                case (ph)
                    PH_HOMING: begin
                        if (!sens_lvl)
                            finish_move();
                    end
                    PH_IDLE: begin
                        if (short_ev || long_ev || cmd_ev) begin
                            led  = 1'b0;
                            tape = 1'b0;
                            if (short_ev || cmd_ev)
                                edges_left = feed_cfg;
                            if (long_ev)
                                falls_left = 2'd1;
                            // Command wins over a long press, a long press over a short one.
                            if (cmd_ev || !long_ev) begin
                                reel = REEL_FWD;
                                ph   = PH_FEED;
                            end else begin
                                reel = REEL_BACK;
                                ph   = PH_BACK;
                            end
                            short_ev = 1'b0;
                            long_ev  = 1'b0;
                            cmd_ev   = 1'b0;
                        end
                    end
                    PH_FEED: begin
                        if (edges_left == 0)
                            finish_move();
                    end
                    default: begin
                        if (falls_left == 0)
                            finish_move();
                    end
                endcase
            end

            d.reel    = reel;
            d.tape    = tape;
            d.led     = led;
            d.phase   = ph;
            d.pausing = (pause_left != 0);
            due_drives.push_back(d);
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t: result %0d: %s", $time, results_seen, msg);
        endtask

        task check_drive(logic [1:0] r, logic t, logic l, logic [1:0] p, logic pz);
            drive_t e;
            results_seen++;
            if (due_drives.size() == 0) begin
                report($sformatf("unexpected transaction reel=%0d phase=%0d", r, p));
            end else begin
                e = due_drives.pop_front();
                if (r !== e.reel)
                    report($sformatf("reel_drive %0d, expected %0d", r, e.reel));
                if (t !== e.tape)
                    report($sformatf("tape_drive %0d, expected %0d", t, e.tape));
                if (l !== e.led)
                    report($sformatf("led_on %0d, expected %0d", l, e.led));
                if (p !== e.phase)
                    report($sformatf("phase %0d, expected %0d", p, e.phase));
                if (pz !== e.pausing)
                    report($sformatf("pausing %0d, expected %0d", pz, e.pausing));
            end
        endtask

        function int pending();
            return due_drives.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_sensor_pin;
    logic                i_button_pin;
    logic                i_command_pin;
    logic                o_valid;
    logic                i_stall;
    logic [1:0]          o_reel_drive;
    logic                o_tape_drive;
    logic                o_led_on;
    logic [1:0]          o_phase;
    logic                o_pausing;
    logic                i_cfg_we;
    logic [CfgIdxW-1:0]  i_cfg_idx;
    logic [CfgDataW-1:0] i_cfg_data;

    tick_scoreboard sb;
    int             send_idle_pct;
    int             stall_pct;
    int             cycle_count;

    // Current settings, kept for shaping the pin waveforms.
    int sens_deb_ticks, cmd_deb_ticks, btn_div_ticks, btn_deb_samples, long_samples;

    // Pin waveform generator: each pin holds a level for a run of ticks.
    logic sens_pin, btn_pin, cmd_pin;
    int   sens_run, btn_run, cmd_run;

    tape_feeder_step_controller dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sensor_pin  (i_sensor_pin),
        .i_button_pin  (i_button_pin),
        .i_command_pin (i_command_pin),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_reel_drive  (o_reel_drive),
        .o_tape_drive  (o_tape_drive),
        .o_led_on      (o_led_on),
        .o_phase       (o_phase),
        .o_pausing     (o_pausing),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Result side: check every accepted transaction, then pick the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_drive(o_reel_drive, o_tape_drive, o_led_on, o_phase, o_pausing);
        i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog.
    initial begin
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // Offer one tick, with random idle cycles ahead of it, and wait until it is taken.
    task automatic send_tick(input logic s, input logic b, input logic c);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_sensor_pin  <= s;
        i_button_pin  <= b;
        i_command_pin <= c;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sb.note_tick(s, b, c);
    endtask

    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= CfgDataW'(value);
        sb.set_reg(idx, CfgDataW'(value));
        @(posedge i_clk);
    endtask

    task automatic apply_settings(input int sdeb, input int cdeb, input int div,
                                  input int bdeb, input int hold, input int feed,
                                  input int pause);
        write_reg(CFG_SENSOR_DEB, sdeb);
        write_reg(CFG_COMMAND_DEB, cdeb);
        write_reg(CFG_BUTTON_DIV, div);
        write_reg(CFG_BUTTON_DEB, bdeb);
        write_reg(CFG_LONG_PRESS, hold);
        write_reg(CFG_FEED_EDGES, feed);
        write_reg(CFG_PAUSE, pause);
        i_cfg_we        <= 1'b0;
        sens_deb_ticks  = sdeb;
        cmd_deb_ticks   = cdeb;
        btn_div_ticks   = div;
        btn_deb_samples = bdeb;
        long_samples    = hold;
    endtask

    // Wait until every predicted transaction has come back.
    task automatic drain();
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int cap_run(int n);
        return (n > RunCap) ? RunCap : ((n < 1) ? 1 : n);
    endfunction

    // Mostly well-formed presses, command pulses and sensor edges, with short glitches.
    task automatic next_pins(output logic s, output logic b, output logic c);
        int samples;
        if (sens_run == 0) begin
            sens_pin = ~sens_pin;
            if ($urandom_range(9) == 0)
                sens_run = 1;
            else
                sens_run = cap_run(sens_deb_ticks + $urandom_range(2));
        end
        if (btn_run == 0) begin
            btn_pin = ~btn_pin;
            if (btn_pin) begin
                btn_run = cap_run((btn_deb_samples + $urandom_range(6, 1)) * btn_div_ticks);
            end else if ($urandom_range(9) == 0) begin
                btn_run = $urandom_range(btn_div_ticks, 1);
            end else begin
                if ($urandom_range(1) == 0)
                    samples = btn_deb_samples + $urandom_range(2);
                else
                    samples = ((long_samples > btn_deb_samples) ? long_samples
                                                               : btn_deb_samples)
                              + $urandom_range(3);
                btn_run = cap_run(samples * btn_div_ticks
                                  + $urandom_range(btn_div_ticks - 1));
            end
        end
        if (cmd_run == 0) begin
            cmd_pin = ~cmd_pin;
            if (cmd_pin)
                cmd_run = cap_run(cmd_deb_ticks + $urandom_range(40, 5));
            else if ($urandom_range(9) == 0)
                cmd_run = 1;
            else
                cmd_run = cap_run(cmd_deb_ticks + $urandom_range(3));
        end
        sens_run--;
        btn_run--;
        cmd_run--;
        s = sens_pin;
        b = btn_pin;
        c = cmd_pin;
    endtask

    initial begin
        logic s, b, c;
        sb            = new();
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_sensor_pin  = 1'b1;
        i_button_pin  = 1'b1;
        i_command_pin = 1'b1;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = '0;
        i_cfg_data    = '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        sens_pin      = 1'b1;
        btn_pin       = 1'b1;
        cmd_pin       = 1'b1;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the shortest settings: homing, a long press and the
        // backward move, a command feed, a short press feed, a command arriving
        // together with a button release, and both inputs asserted at once.
        apply_settings(1, 1, 1, 1, 2, 1, 0);
        send_tick(1, 1, 1); send_tick(0, 1, 1);
        send_tick(0, 0, 1); send_tick(0, 0, 1); send_tick(0, 1, 1);
        send_tick(1, 1, 1); send_tick(0, 1, 1);
        send_tick(0, 1, 0); send_tick(1, 1, 1); send_tick(0, 1, 1);
        send_tick(0, 0, 1); send_tick(0, 1, 1); send_tick(1, 1, 1); send_tick(0, 1, 1);
        send_tick(0, 0, 1); send_tick(0, 1, 0); send_tick(1, 1, 1); send_tick(0, 1, 1);
        send_tick(0, 0, 0); send_tick(0, 0, 0); send_tick(1, 1, 1); send_tick(0, 1, 1);
        i_valid <= 1'b0;

        // Random part, one setting per phase; the all-maximum setting comes last
        // since its pause would hold every later phase.
        for (int ph = 1; ph <= NumPhases; ph++) begin
            drain();
            case (ph)
                1:         apply_settings(1, 1, 1, 1, 1, 1, 0);
                6:         apply_settings(2, 1023, 2, 2, 4095, 255, 3);
                NumPhases: apply_settings(1023, 1023, 255, 1023, 4095, 255, 65535);
                default:   apply_settings($urandom_range(5, 1), $urandom_range(8, 1),
                                          $urandom_range(4, 1), $urandom_range(4, 1),
                                          $urandom_range(12, 1), $urandom_range(8, 1),
                                          $urandom_range(25));
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 14; stall_pct = 14; end
            endcase
            sens_run = 0;
            btn_run  = 0;
            cmd_run  = 0;
            repeat (PhaseTicks) begin
                next_pins(s, b, c);
                send_tick(s, b, c);
            end
            i_valid <= 1'b0;
        end

        stall_pct = 0;
        drain();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
